[design/pmid_pkg.sv]
// Shared types, constants and helper functions of the pairwise distance engine.
`timescale 1ns / 1ps
`default_nettype none
package pmid_pkg;

   localparam int SLOT_WIDTH      = 6;
   localparam int DIST_WIDTH      = 25;
   localparam int BOX_WIDTH       = 24;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int ROOT_STEPS      = 26;
   localparam int SUM_WIDTH       = 52;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = 25'h1FFFFFF;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_SKIP  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATOM_STRIDE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_DIV,
      ST_FIX,
      ST_SQ,
      ST_RINIT,
      ST_ROOT,
      ST_EMIT,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic                  capture;
      logic                  wr_en;
      logic [SLOT_WIDTH-1:0] wr_addr;
      logic                  rd_en;
      logic [SLOT_WIDTH-1:0] rd_addr;
      logic                  load_diff;
      logic                  div_step;
      logic                  fix;
      logic                  sq_en;
      logic [1:0]            sq_sel;
      logic                  root_init;
      logic                  root_step;
      logic                  load_pair;
      logic                  load_mark;
      logic [SLOT_WIDTH-1:0] newer;
      logic [SLOT_WIDTH-1:0] older;
      logic                  ovf;
      logic                  last;
      logic [BOX_WIDTH-1:0]  box_length;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } status_type;

   // Width of the rounding numerator 2*|d| + L.
   function automatic int num_width(input int cw);
      return ((cw + 2 > 25) ? cw + 2 : 25) + 1;
   endfunction

endpackage
`default_nettype wire

[design/pmid_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pmid_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

[design/pmid_ctrl.sv]
// Controller: frame and stride bookkeeping, configuration and pair sequencing.
`timescale 1ns / 1ps
`default_nettype none
module pmid_ctrl #(
   parameter int MAX_ATOMS   = 64,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   input  wire logic                                     req_tlast,
   input  wire logic                                     csr_valid,
   input  wire logic [pmid_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [pmid_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   input  wire pmid_pkg::status_type                     status,
   output pmid_pkg::cmd_type                             cmd
);
   import pmid_pkg::*;

   localparam int CNTW = $clog2(MAX_ATOMS + 1);
   localparam int NW   = num_width(COORD_WIDTH);

   state_type            state_ff, state_in;
   logic [BOX_WIDTH-1:0] box_ff;
   logic [15:0]          skip_cfg_ff, stride_cfg_ff;
   logic [15:0]          skip_ff, skip_in, phase_ff, phase_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in, use_ff, use_in, mid_ff, mid_in;
   logic                 mark_ff, mark_in;
   logic [SLOT_WIDTH-1:0] j_ff, j_in, newer_ff, newer_in;
   logic [5:0]           step_ff, step_in;

   logic [16:0]          skip_next, phase_next;
   logic [15:0]          phase0;
   logic [CNTW-1:0]      cnt0;
   logic                 ovf0, take, full, we;
   logic [SLOT_WIDTH:0]  j_plus;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         box_ff        <= '0;
         skip_cfg_ff   <= 16'd1;
         stride_cfg_ff <= 16'd1;
         skip_ff       <= '0;
         phase_ff      <= '0;
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         use_ff        <= 1'b0;
         mid_ff        <= 1'b0;
         mark_ff       <= 1'b0;
         j_ff          <= '0;
         newer_ff      <= '0;
         step_ff       <= '0;
      end else begin
         state_ff <= state_in;
         skip_ff  <= skip_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         use_ff   <= use_in;
         mid_ff   <= mid_in;
         mark_ff  <= mark_in;
         j_ff     <= j_in;
         newer_ff <= newer_in;
         step_ff  <= step_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_BOX_LENGTH:  box_ff        <= csr_data[BOX_WIDTH-1:0];
               CSR_FRAME_SKIP:  skip_cfg_ff   <= csr_data[15:0];
               CSR_ATOM_STRIDE: stride_cfg_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      skip_in   = skip_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      use_in    = use_ff;
      mid_in    = mid_ff;
      mark_in   = mark_ff;
      j_in      = j_ff;
      newer_in  = newer_ff;
      step_in   = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.box_length = box_ff;
      cmd.newer  = newer_ff;
      cmd.older  = j_ff;
      cmd.ovf    = ovf_ff;
      cmd.rd_addr = j_ff;

      skip_next  = {1'b0, skip_ff} + 17'd1;
      cnt0       = mid_ff ? cnt_ff : '0;
      phase0     = mid_ff ? phase_ff : '0;
      ovf0       = mid_ff ? ovf_ff : 1'b0;
      phase_next = {1'b0, phase0} + 17'd1;
      j_plus     = {1'b0, j_ff} + 7'd1;
      full       = cnt0 >= CNTW'(MAX_ATOMS);
      take       = 1'b0;
      we         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (!mid_ff) begin
                  use_in  = skip_next >= {1'b0, skip_cfg_ff};
                  skip_in = use_in ? 16'd0 : skip_next[15:0];
               end
               phase_in = (phase_next >= {1'b0, stride_cfg_ff}) ? 16'd0 : phase_next[15:0];
               take     = use_in && (phase0 == 16'd0);
               we       = take && !full;
               cnt_in   = we ? cnt0 + CNTW'(1) : cnt0;
               ovf_in   = ovf0 | (take && full);
               mid_in   = !req_tlast;
               mark_in  = req_tlast && use_in;
               cmd.wr_en   = we;
               cmd.wr_addr = SLOT_WIDTH'(cnt0);
               newer_in = SLOT_WIDTH'(cnt0);
               j_in     = '0;
               if (we && cnt0 != '0) begin
                  state_in = ST_READ;
               end else if (mark_in) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.load_diff = 1'b1;
            step_in  = '0;
            state_in = (box_ff == '0) ? ST_FIX : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(NW - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            step_in  = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq_en  = 1'b1;
            cmd.sq_sel = step_ff[1:0];
            step_in    = step_ff + 6'd1;
            if (step_ff == 6'd2) begin
               step_in  = '0;
               state_in = ST_RINIT;
            end
         end
         ST_RINIT: begin
            cmd.root_init = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(ROOT_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_pair = 1'b1;
               cmd.last = (j_plus == {1'b0, newer_ff}) && !mark_ff;
               j_in = j_plus[SLOT_WIDTH-1:0];
               if (j_plus < {1'b0, newer_ff}) begin
                  state_in = ST_READ;
               end else begin
                  state_in = mark_ff ? ST_MARK : ST_IDLE;
               end
            end
         end
         ST_MARK: begin
            if (status.rsp_free) begin
               cmd.load_mark = 1'b1;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[design/pmid_datapath.sv]
// Datapath: atom store, minimum-image remainder, squares, integer root, result register.
`timescale 1ns / 1ps
`default_nettype none
module pmid_datapath #(
   parameter int MAX_ATOMS   = 64,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [3*COORD_WIDTH-1:0]           coords,
   input  wire pmid_pkg::cmd_type                  cmd,
   output pmid_pkg::status_type                    status,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [pmid_pkg::DIST_WIDTH-1:0]         rsp_distance,
   output logic [pmid_pkg::SLOT_WIDTH-1:0]         rsp_newer,
   output logic [pmid_pkg::SLOT_WIDTH-1:0]         rsp_older,
   output logic                                    rsp_marker,
   output logic                                    rsp_ovf,
   output logic                                    rsp_last
);
   import pmid_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int NW   = num_width(CW);
   localparam int MW   = (CW + 1 > DIST_WIDTH) ? CW + 1 : DIST_WIDTH;
   localparam int AW   = $clog2(MAX_ATOMS);
   localparam int RW   = BOX_WIDTH + 1;

   logic [3*CW-1:0]    cur_ff, ram_q;
   logic [DW-1:0]      a_ff  [3];
   logic [NW-1:0]      num_ff[3];
   logic [RW-1:0]      rem_ff[3];
   logic [MW-1:0]      mag_ff[3];
   logic               sat_ff;
   logic [SUM_WIDTH-1:0] sum_ff, v_ff, r_ff, bit_ff;
   logic [SUM_WIDTH-1:0] rb;
   logic [DIST_WIDTH-1:0] pair_distance;
   logic [DIST_WIDTH-1:0] sq_m;
   logic [2*DIST_WIDTH-1:0] sq;
   logic [RW:0]        divisor;
   logic               box_zero;

   assign box_zero = cmd.box_length == '0;
   assign divisor  = {1'b0, cmd.box_length, 1'b0};
   assign status.rsp_free = !rsp_tvalid || rsp_tready;

   pmid_ram #(.WIDTH(3 * CW), .DEPTH(MAX_ATOMS)) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr[AW-1:0]),
      .wr_data (coords),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr[AW-1:0]),
      .rd_data (ram_q)
   );

   assign sq_m = mag_ff[cmd.sq_sel][DIST_WIDTH-1:0];
   assign sq   = sq_m * sq_m;
   assign rb   = r_ff + bit_ff;
   assign pair_distance = sat_ff ? DIST_MAX :
                 ((r_ff > SUM_WIDTH'(DIST_MAX)) ? DIST_MAX : r_ff[DIST_WIDTH-1:0]);

   always_ff @(posedge clock) begin
      logic [DW-1:0]    cur_e, ram_e, diff;
      logic [RW:0]      t;
      logic signed [RW:0] w;
      logic [RW:0]      wa;
      logic [MW-1:0]    m;
      logic             sat_any;
      sat_any = 1'b0;
      if (cmd.capture) begin
         cur_ff <= coords;
      end
      for (int k = 0; k < 3; k++) begin
         cur_e = {cur_ff[k*CW + CW-1], cur_ff[k*CW +: CW]};
         ram_e = {ram_q[k*CW + CW-1], ram_q[k*CW +: CW]};
         diff  = cur_e - ram_e;
         if (cmd.load_diff) begin
            a_ff[k]   <= diff[DW-1] ? DW'(-diff) : diff;
            num_ff[k] <= (NW'(diff[DW-1] ? DW'(-diff) : diff) << 1) + NW'(cmd.box_length);
            rem_ff[k] <= '0;
         end
         t = {rem_ff[k], num_ff[k][NW-1]};
         if (cmd.div_step) begin
            num_ff[k] <= num_ff[k] << 1;
            rem_ff[k] <= (t >= divisor) ? RW'(t - divisor) : RW'(t);
         end
         w  = $signed({1'b0, rem_ff[k]}) - $signed({2'b00, cmd.box_length});
         w  = w >>> 1;
         wa = w[RW] ? RW'(-w) + (RW+1)'(0) : w;
         m  = box_zero ? MW'(a_ff[k]) : MW'(wa[BOX_WIDTH-1:0]);
         sat_any = sat_any | (m > MW'(DIST_MAX));
         if (cmd.fix) begin
            mag_ff[k] <= m;
         end
      end
      if (cmd.fix) begin
         sat_ff <= sat_any;
      end
      if (cmd.sq_en) begin
         sum_ff <= ((cmd.sq_sel == 2'd0) ? '0 : sum_ff) + SUM_WIDTH'(sq);
      end
      if (cmd.root_init) begin
         v_ff   <= sum_ff;
         r_ff   <= '0;
         bit_ff <= SUM_WIDTH'(1) << (2 * (ROOT_STEPS - 1));
      end else if (cmd.root_step) begin
         if (v_ff >= rb) begin
            v_ff <= v_ff - rb;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.load_pair || cmd.load_mark) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pair || cmd.load_mark) begin
         rsp_distance <= cmd.load_pair ? pair_distance : '0;
         rsp_newer    <= cmd.load_pair ? cmd.newer : '0;
         rsp_older    <= cmd.load_pair ? cmd.older : '0;
         rsp_marker   <= cmd.load_mark;
         rsp_ovf      <= cmd.ovf;
         rsp_last     <= cmd.last;
      end
   end
endmodule
`default_nettype wire

[design/pairwise_min_image_distance.sv]
// Top level of the minimum-image pairwise distance engine.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  atom coordinates, end of frame on tlast
//   rsp_      out        rsp_tvalid/rsp_tready  distance and slots, flags on tuser
//   csr_      in         csr_valid/csr_ready    register index and data
//
// Each pair passes the serial remainder unit of COORD_WIDTH + 3 divider steps (at
// least 26), skipped with the box off, and the 26-step root iteration. An item with
// k earlier stored atoms takes k such runs; other items compute no pair, and a
// marker result follows the last item of a frame in use.
// Reset is synchronous and needs no clearing pass. A stalled result holds in the
// output register while the next pair is computed; a new item waits until the last
// result of the current one has been loaded into the output register.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_min_image_distance #(
   parameter int MAX_ATOMS   = 64,
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // x_coord, y_coord, z_coord
   input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  wire logic                                   req_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // distance, newer_slot, older_slot
   output logic [39:0]                                 rsp_tdata,
   // frame_marker, store_overflow
   output logic [1:0]                                  rsp_tuser,
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [pmid_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [pmid_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import pmid_pkg::*;

   cmd_type               cmd;
   status_type            status;
   logic [DIST_WIDTH-1:0] distance;
   logic [SLOT_WIDTH-1:0] newer, older;

   assign csr_ready = 1'b1;

   pmid_ctrl #(.MAX_ATOMS(MAX_ATOMS), .COORD_WIDTH(COORD_WIDTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .status     (status),
      .cmd        (cmd)
   );

   pmid_datapath #(.MAX_ATOMS(MAX_ATOMS), .COORD_WIDTH(COORD_WIDTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .coords       (req_tdata[3*COORD_WIDTH-1:0]),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_distance (distance),
      .rsp_newer    (newer),
      .rsp_older    (older),
      .rsp_marker   (rsp_tuser[0]),
      .rsp_ovf      (rsp_tuser[1]),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, older, newer, distance};

   // A marker carries no distance or slots and always closes its run.
   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[36:0] == 37'd0 && rsp_tlast)
      else $error("marker result carries payload or is not last");

   // A pair always names an earlier slot than the arriving atom.
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[36:31] < rsp_tdata[30:25])
      else $error("pair result with older slot not below newer slot");

   // A result that is not taken stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed or was dropped");
endmodule
`default_nettype wire

[tb/pairwise_min_image_distance_checker.sv]
// Checker that predicts and compares the pair distances and frame markers of the engine.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_min_image_distance_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data,
   output int               failures,
   output int               pending
);
   import pmid_pkg::*;

   typedef struct packed {
      logic [24:0] distance;
      logic [5:0]  newer;
      logic [5:0]  older;
      logic        marker;
      logic        overflow;
      logic        last;
   } pair_result_type;

   pair_result_type expected_pairs[$];
   logic [23:0] box;
   logic [15:0] skip, stride;
   longint xs[64], ys[64], zs[64];
   int unsigned count, stride_ph, skip_ph;
   bit in_use, ovf, mid;

   function automatic longint fold(longint d);
      longint l, a, q;
      l = box;
      if (l == 0) return d;
      a = d < 0 ? -d : d;
      q = (2 * a + l) / (2 * l);
      a -= q * l;
      return d < 0 ? -a : a;
   endfunction

   function automatic logic [24:0] separation(longint dx, longint dy, longint dz);
      longint unsigned ax, ay, az, v, r, b;
      dx = fold(dx);
      dy = fold(dy);
      dz = fold(dz);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      if (ax > DIST_MAX || ay > DIST_MAX || az > DIST_MAX) return DIST_MAX;
      v = ax * ax + ay * ay + az * az;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r > DIST_MAX ? DIST_MAX : r[24:0];
   endfunction

   task automatic predict_atom(logic [71:0] d, logic eof);
      longint x, y, z;
      bit sel;
      int n;
      pair_result_type p;
      x = $signed(d[23:0]);
      y = $signed(d[47:24]);
      z = $signed(d[71:48]);
      n = 0;
      if (!mid) begin
         if (skip_ph + 1 >= skip) begin
            in_use = 1;
            skip_ph = 0;
         end else begin
            in_use = 0;
            skip_ph = (skip_ph + 1) & 16'hFFFF;
         end
         count = 0;
         stride_ph = 0;
         ovf = 0;
         mid = 1;
      end
      sel = stride_ph == 0;
      if (stride_ph + 1 >= stride) stride_ph = 0;
      else stride_ph = (stride_ph + 1) & 16'hFFFF;
      if (in_use && sel) begin
         if (count >= 64) begin
            ovf = 1;
         end else begin
            for (int j = 0; j < count; j++) begin
               p = '{separation(x - xs[j], y - ys[j], z - zs[j]), count[5:0], j[5:0],
                     1'b0, ovf, 1'b0};
               expected_pairs.push_back(p);
               n++;
            end
            xs[count] = x;
            ys[count] = y;
            zs[count] = z;
            count++;
         end
      end
      if (eof) begin
         if (in_use) begin
            p = '{25'd0, 6'd0, 6'd0, 1'b1, ovf, 1'b0};
            expected_pairs.push_back(p);
            n++;
         end
         mid = 0;
      end
      if (n > 0) expected_pairs[$].last = 1'b1;
   endtask

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      failures++;
   endtask

   always @(posedge clock) begin
      pair_result_type got, want;
      if (reset) begin
         box <= '0;
         skip <= 16'd1;
         stride <= 16'd1;
         skip_ph = 0;
         stride_ph = 0;
         count = 0;
         in_use = 0;
         ovf = 0;
         mid = 0;
         failures = 0;
         expected_pairs.delete();
         pending = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BOX_LENGTH:  box <= csr_data;
               CSR_FRAME_SKIP:  skip <= csr_data[15:0];
               CSR_ATOM_STRIDE: stride <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_atom(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[24:0], rsp_tdata[30:25], rsp_tdata[36:31],
                    rsp_tuser[0], rsp_tuser[1], rsp_tlast};
            if (expected_pairs.size() == 0) begin
               report($sformatf("unexpected result %h", got));
            end else begin
               want = expected_pairs.pop_front();
               if (got.distance != want.distance)
                  report($sformatf("distance %h, want %h", got.distance, want.distance));
               if (got.newer != want.newer)
                  report($sformatf("newer_slot %0d, want %0d", got.newer, want.newer));
               if (got.older != want.older)
                  report($sformatf("older_slot %0d, want %0d", got.older, want.older));
               if (got.marker != want.marker) report("frame_marker differs");
               if (got.overflow != want.overflow) report("store_overflow differs");
               if (got.last != want.last) report("last_of_run differs");
            end
         end
         pending = expected_pairs.size();
      end
   end
endmodule
`default_nettype wire

[tb/pairwise_min_image_distance_tb.sv]
// Top of the testbench: stimulus, idling, watchdog and verdict for the engine.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_min_image_distance_tb;
   import pmid_pkg::*;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tlast = 0, rsp_tready = 0, csr_valid = 0;
   logic [71:0] req_tdata = '0;
   logic [1:0] csr_index = CSR_BOX_LENGTH;
   logic [23:0] csr_data = '0;
   wire logic req_tready, rsp_tvalid, rsp_tlast, csr_ready;
   wire logic [39:0] rsp_tdata;
   wire logic [1:0] rsp_tuser;
   int failures, pending, idle_cycles;
   int send_idle = 0, take_idle = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   pairwise_min_image_distance dut (.*);
   pairwise_min_image_distance_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= take_idle);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic send_atom(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic eof);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      req_tlast <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [23:0] b, logic [15:0] s, logic [15:0] a);
      drain();
      write_reg(CSR_BOX_LENGTH, b);
      write_reg(CSR_FRAME_SKIP, {8'd0, s});
      write_reg(CSR_ATOM_STRIDE, {8'd0, a});
      csr_valid <= 0;
   endtask

   function automatic logic [23:0] coord(int mode);
      case (mode)
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(4095) - 2048);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_frames(int atoms);
      int n, mode;
      while (atoms > 0) begin
         n = $urandom_range(8, 1);
         if ($urandom_range(9) == 0) n = $urandom_range(70, 60);
         if (n > atoms) n = atoms;
         mode = $urandom_range(3);
         for (int i = 0; i < n; i++) begin
            send_atom(coord(mode), coord(mode), coord(mode), i == n - 1);
            atoms--;
         end
      end
   endtask

   initial begin
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      configure(24'd0, 16'd1, 16'd1);
      send_atom(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
      send_atom(24'h800000, 24'h800000, 24'h800000, 0);
      send_atom(24'h000000, 24'h000000, 24'h000000, 0);
      send_atom(24'h000100, 24'hFFFF00, 24'h000080, 1);
      send_atom(24'h000010, 24'h000020, 24'h000030, 1);
      configure(24'h000400, 16'd1, 16'd1);
      send_atom(24'h000000, 24'h000000, 24'h000000, 0);
      send_atom(24'h000200, 24'hFFFE00, 24'h000300, 0);
      send_atom(24'h7FFFFF, 24'h800000, 24'h000600, 1);
      configure(24'hFFFFFF, 16'd2, 16'd2);
      for (int i = 0; i < 8; i++) send_atom(coord(3), coord(3), coord(3), i % 4 == 3);
      configure(24'h000001, 16'd0, 16'd0);
      send_atom(24'h000005, 24'h000003, 24'hFFFFFD, 0);
      send_atom(24'h000001, 24'h000000, 24'h000000, 1);
      configure(24'd0, 16'hFFFF, 16'hFFFF);
      send_atom(24'h000001, 24'h000002, 24'h000003, 1);
      configure(24'd0, 16'd1, 16'd1);
      for (int i = 0; i < 66; i++) send_atom(coord(2), coord(2), coord(2), i == 65);
      send_idle = 24;
      take_idle = 54;
      configure(24'($urandom_range(24'h4000)), 16'd1, 16'd1);
      random_frames(12);
      send_idle = 54;
      take_idle = 24;
      configure(24'($urandom), 16'($urandom_range(3, 1)), 16'($urandom_range(3, 1)));
      random_frames(12);
      send_idle = 0;
      take_idle = 0;
      configure(24'd0, 16'd1, 16'd2);
      random_frames(12);
      drain();
      if (failures == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
design/pmid_pkg.sv
design/pmid_ram.sv
design/pmid_ctrl.sv
design/pmid_datapath.sv
design/pairwise_min_image_distance.sv
tb/pairwise_min_image_distance_checker.sv
tb/pairwise_min_image_distance_tb.sv
